// ===== hw/rtl/lottery_ticket_table_defines.svh =====
// Assertion macros for the lottery ticket table.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef LOTTERY_TICKET_TABLE_DEFINES_SVH
`define LOTTERY_TICKET_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define LTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LTT_ASSERT_IMP(lbl, ante, cons, msg)

`define LTT_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/ltt_pkg.sv =====
`default_nettype none

package ltt_pkg;

  // Field widths of the request and response beats.
  localparam int MODE_W   = 3;
  localparam int SLOT_W   = 4;
  localparam int TICKET_W = 16;
  localparam int STATUS_W = 2;

  // Default sizing of the table.
  localparam int DEF_SLOTS       = 16;
  localparam int DEF_TICKET_BITS = 16;

  // Operation codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_GIVE   = 3'd1,
    MODE_TAKE   = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_LOOKUP = 3'd4
  } mode_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NO_MATCH = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take in the request beat and read the addressed slot
    logic calc;     // register the sums for the addressed slot
    logic decide;   // settle the status, update valid bits, arm the sweep
    logic sweep;    // step through the table one entry per cycle
    logic load;     // fill the response register
  } ltt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_done;
    logic out_free;
  } ltt_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ltt_if.sv =====
`default_nettype none

// Request channel: one operation per beat.
interface ltt_req_if
  import ltt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [SLOT_W-1:0]   slot;
  logic [TICKET_W-1:0] ticket_count;
  logic [TICKET_W-1:0] ticket_number;

  modport source (output valid, mode, slot, ticket_count, ticket_number, input ready);
  modport sink   (input valid, mode, slot, ticket_count, ticket_number, output ready);
endinterface

// Response channel: one result per beat.
interface ltt_rsp_if
  import ltt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   found_slot;
  logic [TICKET_W-1:0] range_low;
  logic [TICKET_W-1:0] range_high;
  logic [TICKET_W-1:0] next_free_ticket;

  modport source (output valid, status, found_slot, range_low, range_high, next_free_ticket,
                  input ready);
  modport sink   (input valid, status, found_slot, range_low, range_high, next_free_ticket,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ltt_ctrl.sv =====
`default_nettype none

module ltt_ctrl
  import ltt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  ltt_sts_t sts_i,
  output ltt_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_DECIDE,
    S_SWEEP,
    S_FINISH
  } state_e;

  state_e state_q;
  state_e state_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_CALC;
      end
      S_CALC:   state_d = S_DECIDE;
      S_DECIDE: state_d = S_SWEEP;
      S_SWEEP: begin
        if (sts_i.sweep_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands follow the state.
  assign req_ready_o   = (state_q == S_IDLE);
  assign cmd_o.capture = (state_q == S_IDLE) && req_valid_i;
  assign cmd_o.calc    = (state_q == S_CALC);
  assign cmd_o.decide  = (state_q == S_DECIDE);
  assign cmd_o.sweep   = (state_q == S_SWEEP);
  assign cmd_o.load    = (state_q == S_FINISH) && sts_i.out_free;

endmodule

`default_nettype wire

// ===== hw/rtl/ltt_datapath.sv =====
`default_nettype none
`include "lottery_ticket_table_defines.svh"

module ltt_datapath
  import ltt_pkg::*;
#(
  parameter int SLOTS       = DEF_SLOTS,
  parameter int TICKET_BITS = DEF_TICKET_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ltt_cmd_t            cmd_i,
  output ltt_sts_t            sts_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [TICKET_W-1:0] count_i,
  input  logic [TICKET_W-1:0] ticket_i,
  input  logic                rsp_ready_i,
  output logic                rsp_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   found_slot_o,
  output logic [TICKET_W-1:0] range_low_o,
  output logic [TICKET_W-1:0] range_high_o,
  output logic [TICKET_W-1:0] next_free_o
);

  localparam int TW = TICKET_BITS;
  // Arithmetic width: room for the ticket space, the 16-bit fields and a carry.
  localparam int AW = ((TW > TICKET_W) ? TW : TICKET_W) + 1;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // Request registers.
  logic [MODE_W-1:0]   mode_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [TICKET_W-1:0] count_q;
  logic [TICKET_W-1:0] ticket_q;
  logic                sok;
  logic [IW-1:0]       s_idx;

  // Table storage.
  logic [SLOTS-1:0] valid_q;
  logic [TW-1:0]    start_mem [SLOTS];
  logic [TW-1:0]    end_mem [SLOTS];
  logic [TW-1:0]    rd_start_q;
  logic [TW-1:0]    rd_end_q;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;
  logic [TW-1:0]    wr_start;
  logic [TW-1:0]    wr_end;

  // Running table summary.
  logic [TW-1:0] top_q;
  logic [AW-1:0] nf_q;

  // Addressed slot and its sums.
  logic [TW-1:0] s_start_q;
  logic [TW-1:0] s_end_q;
  logic [TW-1:0] spare_q;
  logic [AW-1:0] ins_end_q;
  logic [AW-1:0] give_sum_q;
  logic          was_valid_q;

  // Decision.
  status_e       dec_st;
  logic          dec_mod;
  logic          dec_shift;
  logic          dec_up;
  logic [TW-1:0] dec_delta;
  logic [TW-1:0] dec_start;
  logic [TW-1:0] dec_end;
  logic          dec_show;
  logic          dec_lookup;
  logic          dec_set;
  logic          dec_clr;
  logic [TW-1:0] dec_lo;
  logic [TW-1:0] dec_hi;
  logic [TW-1:0] taken;
  status_e       st_q;
  logic          mod_en_q;
  logic          shift_en_q;
  logic          shift_up_q;
  logic          lookup_q;
  logic [TW-1:0] delta_q;
  logic [TW-1:0] new_start_q;
  logic [TW-1:0] new_end_q;
  logic [TW-1:0] res_lo_q;
  logic [TW-1:0] res_hi_q;

  // Sweep pipeline and accumulators.
  logic [CW-1:0] idx_q;
  logic          p_vld_q;
  logic [IW-1:0] p_idx_q;
  logic          p_v;
  logic          p_is_s;
  logic          p_shift;
  logic [TW-1:0] p_end;
  logic          p_hit;
  logic [TW-1:0] top_acc_q;
  logic          any_acc_q;
  logic          found_q;
  logic [IW-1:0] f_idx_q;
  logic [TW-1:0] f_lo_q;
  logic [TW-1:0] f_hi_q;
  logic [AW-1:0] nf_new;

  // Response register.
  logic                out_valid_q;
  status_e             status_q;
  logic [SLOT_W-1:0]   fslot_q;
  logic [TICKET_W-1:0] lo_q;
  logic [TICKET_W-1:0] hi_q;
  logic [TICKET_W-1:0] nf_out_q;

  assign sok   = 32'(slot_q) < SLOTS;
  assign s_idx = IW'(slot_q);

  // Capture the request beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q   <= mode_i;
      slot_q   <= slot_i;
      count_q  <= count_i;
      ticket_q <= ticket_i;
    end
  end

  // Single read port: the addressed slot on capture, then one entry per sweep cycle.
  assign rd_en   = cmd_i.capture || (cmd_i.sweep && (idx_q < CW'(SLOTS)));
  assign rd_addr = cmd_i.capture ? IW'(slot_i) : idx_q[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_start_q <= start_mem[rd_addr];
      rd_end_q   <= end_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      start_mem[p_idx_q] <= wr_start;
      end_mem[p_idx_q]   <= wr_end;
    end
  end

  // Sums for the addressed slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      s_start_q   <= rd_start_q;
      s_end_q     <= rd_end_q;
      spare_q     <= rd_end_q - rd_start_q;
      ins_end_q   <= nf_q + AW'(count_q) - AW'(1);
      give_sum_q  <= AW'(top_q) + AW'(count_q);
      was_valid_q <= sok && valid_q[s_idx];
    end
  end

  // Settle the operation from the addressed slot and the table summary.
  always_comb begin
    dec_st     = ST_INVALID;
    dec_mod    = 1'b0;
    dec_shift  = 1'b0;
    dec_up     = 1'b0;
    dec_delta  = '0;
    dec_start  = s_start_q;
    dec_end    = s_end_q;
    dec_show   = 1'b1;
    dec_lookup = 1'b0;
    dec_set    = 1'b0;
    dec_clr    = 1'b0;
    taken      = (AW'(count_q) > AW'(spare_q)) ? spare_q : TW'(count_q);
    case (mode_e'(mode_q))
      MODE_INSERT: begin
        if (sok && !was_valid_q && (count_q != '0)) begin
          if (ins_end_q[AW-1:TW] != '0) begin
            dec_st = ST_OVERFLOW;
          end else begin
            dec_st    = ST_OK;
            dec_mod   = 1'b1;
            dec_set   = 1'b1;
            dec_start = nf_q[TW-1:0];
            dec_end   = ins_end_q[TW-1:0];
          end
        end
      end
      MODE_GIVE: begin
        if (was_valid_q) begin
          if (give_sum_q[AW-1:TW] != '0) begin
            dec_st = ST_OVERFLOW;
          end else begin
            dec_st    = ST_OK;
            dec_mod   = 1'b1;
            dec_shift = 1'b1;
            dec_up    = 1'b1;
            dec_delta = TW'(count_q);
            dec_end   = TW'(AW'(s_end_q) + AW'(count_q));
          end
        end
      end
      MODE_TAKE: begin
        if (was_valid_q) begin
          dec_st    = ST_OK;
          dec_mod   = 1'b1;
          dec_shift = 1'b1;
          dec_delta = taken;
          dec_end   = s_end_q - taken;
        end
      end
      MODE_REMOVE: begin
        if (was_valid_q) begin
          dec_st    = ST_OK;
          dec_clr   = 1'b1;
          dec_shift = 1'b1;
          dec_delta = spare_q + TW'(1);
          dec_show  = 1'b0;
        end
      end
      MODE_LOOKUP: begin
        dec_lookup = 1'b1;
      end
      default: begin
        dec_st = ST_INVALID;
      end
    endcase
    // Range shown for the addressed slot after the operation.
    if (dec_mod) begin
      dec_lo = dec_start;
      dec_hi = dec_end;
    end else if (dec_show && was_valid_q) begin
      dec_lo = s_start_q;
      dec_hi = s_end_q;
    end else begin
      dec_lo = '0;
      dec_hi = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      st_q        <= dec_st;
      mod_en_q    <= dec_mod;
      shift_en_q  <= dec_shift;
      shift_up_q  <= dec_up;
      lookup_q    <= dec_lookup;
      delta_q     <= dec_delta;
      new_start_q <= dec_start;
      new_end_q   <= dec_end;
      res_lo_q    <= dec_lo;
      res_hi_q    <= dec_hi;
    end
  end

  // Valid bits change only when an operation is settled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.decide) begin
      if (dec_set) valid_q[s_idx] <= 1'b1;
      if (dec_clr) valid_q[s_idx] <= 1'b0;
    end
  end

  // Process the entry read in the previous cycle: rewrite, shift, track top and search.
  always_comb begin
    p_v     = p_vld_q && valid_q[p_idx_q];
    p_is_s  = p_vld_q && mod_en_q && (p_idx_q == s_idx);
    p_shift = p_v && shift_en_q && (rd_start_q > s_end_q);
    wr_en   = p_is_s || p_shift;
    if (p_is_s) begin
      wr_start = new_start_q;
      wr_end   = new_end_q;
    end else if (shift_up_q) begin
      wr_start = rd_start_q + delta_q;
      wr_end   = rd_end_q + delta_q;
    end else begin
      wr_start = rd_start_q - delta_q;
      wr_end   = rd_end_q - delta_q;
    end
    p_end = wr_en ? wr_end : rd_end_q;
    p_hit = p_v && lookup_q && !found_q
            && (AW'(rd_start_q) <= AW'(ticket_q)) && (AW'(ticket_q) <= AW'(rd_end_q));
  end

  // Sweep counter and read pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      p_vld_q <= 1'b0;
      p_idx_q <= '0;
    end else if (cmd_i.decide) begin
      idx_q   <= '0;
      p_vld_q <= 1'b0;
    end else if (cmd_i.sweep && (idx_q < CW'(SLOTS))) begin
      idx_q   <= idx_q + CW'(1);
      p_vld_q <= 1'b1;
      p_idx_q <= idx_q[IW-1:0];
    end else begin
      p_vld_q <= 1'b0;
    end
  end

  // Accumulators over the sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_acc_q <= '0;
      any_acc_q <= 1'b0;
      found_q   <= 1'b0;
      f_idx_q   <= '0;
      f_lo_q    <= '0;
      f_hi_q    <= '0;
    end else if (cmd_i.decide) begin
      top_acc_q <= '0;
      any_acc_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      if (p_v && (p_end > top_acc_q)) top_acc_q <= p_end;
      if (p_v) any_acc_q <= 1'b1;
      if (p_hit) begin
        found_q <= 1'b1;
        f_idx_q <= p_idx_q;
        f_lo_q  <= rd_start_q;
        f_hi_q  <= rd_end_q;
      end
    end
  end

  assign nf_new = any_acc_q ? (AW'(top_acc_q) + AW'(1)) : AW'(1);

  // Table summary kept for the next operation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      nf_q  <= AW'(1);
    end else if (cmd_i.load) begin
      top_q <= top_acc_q;
      nf_q  <= nf_new;
    end
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      nf_out_q <= TICKET_W'(nf_new);
      if (!lookup_q) begin
        status_q <= st_q;
        fslot_q  <= slot_q;
        lo_q     <= TICKET_W'(res_lo_q);
        hi_q     <= TICKET_W'(res_hi_q);
      end else if (found_q) begin
        status_q <= ST_OK;
        fslot_q  <= SLOT_W'(f_idx_q);
        lo_q     <= TICKET_W'(f_lo_q);
        hi_q     <= TICKET_W'(f_hi_q);
      end else begin
        status_q <= ST_NO_MATCH;
        fslot_q  <= '0;
        lo_q     <= '0;
        hi_q     <= '0;
      end
    end
  end

  assign sts_o.sweep_done = (idx_q == CW'(SLOTS));
  assign sts_o.out_free   = !out_valid_q || rsp_ready_i;
  assign rsp_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_slot_o     = fslot_q;
  assign range_low_o      = lo_q;
  assign range_high_o     = hi_q;
  assign next_free_o      = nf_out_q;

  // Valid bits move only in the decide cycle, and by at most one slot.
  `LTT_ASSERT_NXT(a_valid_only_on_decide, !cmd_i.decide, $stable(valid_q), "valid bits changed outside decide")
  `LTT_ASSERT_NXT(a_one_slot_per_item, cmd_i.decide, ($countones(valid_q) <= $countones($past(valid_q)) + 1) && ($countones(valid_q) + 1 >= $countones($past(valid_q))), "more than one slot changed")
  // The response register is never overwritten while a beat waits.
  `LTT_ASSERT_IMP(a_load_when_free, cmd_i.load, !out_valid_q || rsp_ready_i, "response overwritten")
  // A lookup hit always carries an ordered range.
  `LTT_ASSERT_IMP(a_hit_range_ordered, found_q, f_lo_q <= f_hi_q, "lookup hit with inverted range")

endmodule

`default_nettype wire

// ===== hw/rtl/lottery_ticket_table.sv =====
`default_nettype none

// Lottery ticket table: up to SLOTS clients, each holding one contiguous range of tickets
// packed upward from ticket 1. Each request beat runs one operation (insert, give, take,
// remove or lookup) and yields exactly one response beat with the status, the slot, its
// range after the operation and the next free ticket. One request is worked at a time: after
// acceptance it forms the sums, settles the operation, sweeps the table and loads the
// response. The ranges live in a memory with one read port, and every operation sweeps it
// one entry per cycle to shift ranges, rebuild the highest range end and search for the
// drawn ticket. The next request can be accepted from the cycle after the load; a response
// that is held off stalls the load and with it the next request.
// The response sits in an output register, so the next request is accepted while it waits.
// After reset the table is empty and usable at once.
module lottery_ticket_table
  import ltt_pkg::*;
#(
  parameter int SLOTS       = DEF_SLOTS,
  parameter int TICKET_BITS = DEF_TICKET_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ltt_req_if.sink    req_i,
  ltt_rsp_if.source  rsp_o
);

  ltt_cmd_t cmd;
  ltt_sts_t sts;

  ltt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ltt_datapath #(
    .SLOTS       (SLOTS),
    .TICKET_BITS (TICKET_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (req_i.mode),
    .slot_i       (req_i.slot),
    .count_i      (req_i.ticket_count),
    .ticket_i     (req_i.ticket_number),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .status_o     (rsp_o.status),
    .found_slot_o (rsp_o.found_slot),
    .range_low_o  (rsp_o.range_low),
    .range_high_o (rsp_o.range_high),
    .next_free_o  (rsp_o.next_free_ticket)
  );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ltt_pkg::*;

  localparam int          SLOTS          = DEF_SLOTS;
  localparam int unsigned TICKET_TOP     = (32'd1 << DEF_TICKET_BITS) - 1;
  localparam int          PHASE_OPS      = 463;
  localparam int          LONG_HOLD      = 400;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 50;
  localparam int          MAX_REPORTS    = 40;

  // Mode codes outside the defined operations; the block must refuse them.
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SLOT_W-1:0]   slot;
    logic [TICKET_W-1:0] count;
    logic [TICKET_W-1:0] number;
  } ticket_op_t;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic [TICKET_W-1:0] low;
    logic [TICKET_W-1:0] high;
    logic [TICKET_W-1:0] next_free;
  } ticket_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ltt_req_if req_if ();
  ltt_rsp_if rsp_if ();

  lottery_ticket_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  // Mirror of the ticket table, updated when a request beat is accepted.
  bit          slot_used[SLOTS];
  int unsigned first_ticket[SLOTS];
  int unsigned last_ticket[SLOTS];

  ticket_op_t     pending_ops[$];
  ticket_result_t expected_results[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int holds_served;
  int hold_left;
  int mismatches;
  int idle_cycles;
  int ops_by_mode[8];
  int results_by_status[4];

  function automatic int unsigned highest_end();
    int unsigned top;
    top = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && last_ticket[i] > top) top = last_ticket[i];
    end
    return top;
  endfunction

  function automatic int unsigned next_free_ticket();
    bit any;
    any = 1'b0;
    for (int i = 0; i < SLOTS; i++) any |= slot_used[i];
    return any ? highest_end() + 1 : 1;
  endfunction

  // Move every range above the limit, except the touched slot, by delta.
  function automatic void shift_ranges(int unsigned limit, int skip, int unsigned delta,
                                       bit up);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && i != skip && first_ticket[i] > limit) begin
        if (up) begin
          first_ticket[i] += delta;
          last_ticket[i]  += delta;
        end else begin
          first_ticket[i] -= delta;
          last_ticket[i]  -= delta;
        end
      end
    end
  endfunction

  // Apply one operation to the mirror and return the response it must produce.
  function automatic ticket_result_t apply_ticket_op(ticket_op_t op);
    ticket_result_t res;
    int unsigned    s, cnt, start, prev, spare, taken, free_at;
    bit             show, hit;
    s          = op.slot;
    cnt        = op.count;
    res.status = ST_INVALID;
    res.slot   = op.slot;
    res.low    = '0;
    res.high   = '0;
    show       = 1'b1;
    case (op.mode)
      MODE_INSERT: begin
        if (!slot_used[s] && cnt >= 1) begin
          start = next_free_ticket();
          if (start + cnt - 1 > TICKET_TOP) begin
            res.status = ST_OVERFLOW;
          end else begin
            slot_used[s]    = 1'b1;
            first_ticket[s] = start;
            last_ticket[s]  = start + cnt - 1;
            res.status      = ST_OK;
          end
        end
      end
      MODE_GIVE: begin
        if (slot_used[s]) begin
          if (highest_end() + cnt > TICKET_TOP) begin
            res.status = ST_OVERFLOW;
          end else begin
            prev           = last_ticket[s];
            last_ticket[s] = prev + cnt;
            shift_ranges(prev, s, cnt, 1'b1);
            res.status     = ST_OK;
          end
        end
      end
      MODE_TAKE: begin
        if (slot_used[s]) begin
          prev           = last_ticket[s];
          spare          = prev - first_ticket[s];
          taken          = (cnt > spare) ? spare : cnt;
          last_ticket[s] = prev - taken;
          shift_ranges(prev, s, taken, 1'b0);
          res.status     = ST_OK;
        end
      end
      MODE_REMOVE: begin
        if (slot_used[s]) begin
          prev         = last_ticket[s];
          slot_used[s] = 1'b0;
          shift_ranges(prev, s, prev - first_ticket[s] + 1, 1'b0);
          res.status   = ST_OK;
          show         = 1'b0;
        end
      end
      MODE_LOOKUP: begin
        res.status = ST_NO_MATCH;
        res.slot   = '0;
        show       = 1'b0;
        hit        = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!hit && slot_used[i] && first_ticket[i] <= op.number &&
              op.number <= last_ticket[i]) begin
            hit        = 1'b1;
            res.status = ST_OK;
            res.slot   = SLOT_W'(i);
            res.low    = first_ticket[i][TICKET_W-1:0];
            res.high   = last_ticket[i][TICKET_W-1:0];
          end
        end
      end
      default: ;
    endcase
    if (show && slot_used[s]) begin
      res.low  = first_ticket[s][TICKET_W-1:0];
      res.high = last_ticket[s][TICKET_W-1:0];
    end
    free_at       = next_free_ticket();
    res.next_free = free_at[TICKET_W-1:0];
    return res;
  endfunction

  // Random operation steered by the mirror: inserts mostly hit free slots, give/take/remove live ones.
  function automatic ticket_op_t random_ticket_op();
    ticket_op_t  op;
    int          used_list[$];
    int          free_list[$];
    int          pick, count_pick;
    int unsigned room, free_at;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i]) used_list.push_back(i);
      else free_list.push_back(i);
    end
    pick      = $urandom_range(0, 99);
    op.slot   = SLOT_W'($urandom);
    op.number = TICKET_W'($urandom);
    if (pick < 26) begin
      op.mode = MODE_INSERT;
      if (free_list.size() != 0 && $urandom_range(0, 99) < 85)
        op.slot = SLOT_W'(free_list[$urandom_range(0, free_list.size() - 1)]);
    end else if (pick < 78) begin
      op.mode = (pick < 46) ? MODE_GIVE : (pick < 66) ? MODE_TAKE : MODE_REMOVE;
      if (used_list.size() != 0 && $urandom_range(0, 99) < 85)
        op.slot = SLOT_W'(used_list[$urandom_range(0, used_list.size() - 1)]);
    end else if (pick < 97) begin
      op.mode = MODE_LOOKUP;
      free_at = next_free_ticket();
      if (free_at > TICKET_TOP) free_at = TICKET_TOP;
      if ($urandom_range(0, 99) < 75) op.number = TICKET_W'($urandom_range(0, free_at));
    end else begin
      op.mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    end
    // Mostly small counts, some anywhere, some right at the edge of the ticket space.
    count_pick = $urandom_range(0, 99);
    room       = TICKET_TOP - highest_end();
    if (count_pick < 7) op.count = TICKET_W'($urandom);
    else if (count_pick < 13) op.count = TICKET_W'(room + $urandom_range(0, 2) - 1);
    else op.count = TICKET_W'($urandom_range(0, 40));
    return op;
  endfunction

  function automatic bit drained();
    return pending_ops.size() == 0 && !req_if.valid && expected_results.size() == 0;
  endfunction

  task automatic queue_op(logic [MODE_W-1:0] mode, int slot, int unsigned count,
                          int unsigned number);
    ticket_op_t op;
    op.mode   = mode;
    op.slot   = SLOT_W'(slot);
    op.count  = TICKET_W'(count);
    op.number = TICKET_W'(number);
    pending_ops.push_back(op);
  endtask

  task automatic wait_drained();
    while (!drained()) @(negedge clk_i);
  endtask

  task automatic report_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Request driver: predicts each accepted beat, then offers the next one.
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    ticket_op_t     sent, next_op;
    ticket_result_t outcome;
    if (!rst_ni) begin
      req_if.valid         <= 1'b0;
      req_if.mode          <= '0;
      req_if.slot          <= '0;
      req_if.ticket_count  <= '0;
      req_if.ticket_number <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        sent.mode   = req_if.mode;
        sent.slot   = req_if.slot;
        sent.count  = req_if.ticket_count;
        sent.number = req_if.ticket_number;
        outcome     = apply_ticket_op(sent);
        expected_results.push_back(outcome);
        ops_by_mode[sent.mode]++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_op               = pending_ops.pop_front();
          req_if.valid         <= 1'b1;
          req_if.mode          <= next_op.mode;
          req_if.slot          <= next_op.slot;
          req_if.ticket_count  <= next_op.count;
          req_if.ticket_number <= next_op.number;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: checks each beat against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : response_monitor
    ticket_result_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      holds_served <= 0;
      hold_left    <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_by_status[rsp_if.status]++;
        if (expected_results.size() == 0) begin
          $display("%0t ns: response beat with nothing expected, status %0d slot %0d",
                   $time, rsp_if.status, rsp_if.found_slot);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          report_field("status", want.status, rsp_if.status);
          report_field("found_slot", want.slot, rsp_if.found_slot);
          report_field("range_low", want.low, rsp_if.range_low);
          report_field("range_high", want.high, rsp_if.range_high);
          report_field("next_free_ticket", want.next_free, rsp_if.next_free_ticket);
        end
      end
      // A long hold-off lets the block fill up and push back on requests.
      if (holds_served != hold_requests) begin
        holds_served <= holds_served + 1;
        hold_left    <= LONG_HOLD;
        rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles", $time, idle_cycles);
        $display("[lottery_ticket_table] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int idle_plan[4];
    int stall_plan[4];
    idle_plan  = '{0, 88, 0, 33};
    stall_plan = '{0, 0, 88, 33};
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.mode          = '0;
    req_if.slot          = '0;
    req_if.ticket_count  = '0;
    req_if.ticket_number = '0;
    rsp_if.ready         = 1'b0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    hold_requests        = 0;
    mismatches           = 0;
    idle_cycles          = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, refusals, the top of the ticket space and shifting.
    queue_op(MODE_LOOKUP, 0, 0, 0);
    queue_op(MODE_GIVE, 0, 1, 0);
    queue_op(MODE_TAKE, 3, 1, 0);
    queue_op(MODE_REMOVE, 15, 0, 0);
    queue_op(MODE_INSERT, 0, 0, 0);
    queue_op(MODE_INSERT, 0, 1, 0);
    queue_op(MODE_INSERT, 0, 5, 0);
    queue_op(MODE_INSERT, 15, TICKET_TOP, 0);
    queue_op(MODE_INSERT, 15, TICKET_TOP - 1, 0);
    queue_op(MODE_LOOKUP, 0, 0, TICKET_TOP);
    queue_op(MODE_LOOKUP, 0, 0, 1);
    queue_op(MODE_GIVE, 0, 1, 0);
    queue_op(MODE_GIVE, 0, 0, 0);
    queue_op(MODE_INSERT, 5, 1, 0);
    queue_op(MODE_TAKE, 15, TICKET_TOP, 0);
    queue_op(MODE_TAKE, 0, 5, 0);
    queue_op(MODE_GIVE, 0, TICKET_TOP - 2, 0);
    queue_op(MODE_UNUSED_LO, 0, 1, 1);
    queue_op(MODE_UNUSED_LO + MODE_W'(1), 15, TICKET_TOP, TICKET_TOP);
    queue_op(MODE_UNUSED_HI, 7, 0, 0);
    queue_op(MODE_REMOVE, 0, 0, 0);
    queue_op(MODE_LOOKUP, 0, 0, 1);
    queue_op(MODE_REMOVE, 15, 0, 0);
    queue_op(MODE_LOOKUP, 0, TICKET_TOP, TICKET_TOP);
    wait_drained();

    // Random phases with different idle and stall rates, each ending fully drained.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_plan[phase];
      recv_stall_pct = stall_plan[phase];
      for (int n = 0; n < PHASE_OPS; n++) begin
        if (phase == 0 && n == PHASE_OPS / 3) hold_requests++;
        @(negedge clk_i);
        while (pending_ops.size() != 0) @(negedge clk_i);
        pending_ops.push_back(random_ticket_op());
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t ns: %0d responses never arrived", $time, expected_results.size());
      mismatches++;
    end
    $display("Covered %0d operations: insert %0d, give %0d, take %0d, remove %0d, lookup %0d,",
             ops_by_mode.sum(), ops_by_mode[MODE_INSERT], ops_by_mode[MODE_GIVE],
             ops_by_mode[MODE_TAKE], ops_by_mode[MODE_REMOVE], ops_by_mode[MODE_LOOKUP]);
    $display("unused modes %0d; responses ok %0d, refused %0d, no match %0d, overflow %0d.",
             ops_by_mode[5] + ops_by_mode[6] + ops_by_mode[7], results_by_status[ST_OK],
             results_by_status[ST_INVALID], results_by_status[ST_NO_MATCH],
             results_by_status[ST_OVERFLOW]);
    if (mismatches == 0) begin
      $display("[lottery_ticket_table] OK");
    end else begin
      $display("[lottery_ticket_table] ERROR");
    end
    $finish;
  end

endmodule
